FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the image slot table.
// Needs signals named clk and rst_n in the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define AST_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/isqt_pkg.sv
// Shared types and constants for the image slot table.
// No dependencies.
`timescale 1ns / 1ps

package isqt_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int FUNC_W        = 2;
    localparam int SLOT_W        = 5;
    localparam int ID_W          = 16;
    localparam int PK_W          = 16;

    // request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_STORE   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_OLDEST  = 2'd2,
        FUNC_LOOKUP  = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_FIN   = 2'd3
    } state_t;

    // flags from the shared comparator
    typedef struct packed {
        logic eq;       // a equals b
        logic earlier;  // a is earlier than b in serial order
    } cmp_res_t;

endpackage

FILE: sv/isqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module isqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/isqt_cmp.sv
// Shared 16-bit comparator: equality and serial-number ordering.
// Depends on isqt_pkg.
`timescale 1ns / 1ps

module isqt_cmp (
    input  logic [isqt_pkg::ID_W-1:0] a,
    input  logic [isqt_pkg::ID_W-1:0] b,
    output isqt_pkg::cmp_res_t        res
);

    import isqt_pkg::*;

    logic [ID_W-1:0] diff;

    // one subtract serves both checks; a wrapped negative difference means earlier
    always_comb
    begin
        diff        = a - b;
        res.eq      = (diff == '0);
        res.earlier = diff[ID_W-1];
    end

endmodule

FILE: sv/image_slot_queue_table.sv
// Image slot table: top level with sequencer, occupancy bits and output register.
// Depends on isqt_pkg, isqt_ram, isqt_cmp and assert_macros.svh.
//
// Usage:
//   Request channel (in_valid / in_stall) carries func, slot, exclude_enable,
//   image_id and packets. Result channel (out_valid / out_stall) carries ok,
//   result_slot, result_id and result_packets, one result per request.
//   Store takes the lowest free slot, release clears a slot, find oldest
//   returns the earliest image number, lookup searches for an image number.
//   Release goes straight to the result phase; store walks the occupancy
//   bits up to the first free slot, or through all of them with none free;
//   find oldest and lookup walk every slot. The next request is taken in
//   the cycle after the result register is loaded. The scan takes one slot
//   per cycle; find oldest and lookup read each slot through the single
//   read port of the slot RAM and the one shared comparator.
//   in_stall is high while a request is in work; a new request is taken
//   while a finished result still waits in the output register.
//   If the receiver stalls, the finished request waits until the output
//   register frees up; nothing is lost.
//   Reset clears the occupancy bits (every slot free) and the number
//   counter; no clearing pass is needed, the block is ready at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module image_slot_queue_table #(
    parameter int SLOTS = isqt_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [isqt_pkg::FUNC_W-1:0] func,
    input  logic [isqt_pkg::SLOT_W-1:0] slot,
    input  logic                        exclude_enable,
    input  logic [isqt_pkg::ID_W-1:0]   image_id,
    input  logic [isqt_pkg::PK_W-1:0]   packets,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ok,
    output logic [isqt_pkg::SLOT_W-1:0] result_slot,
    output logic [isqt_pkg::ID_W-1:0]   result_id,
    output logic [isqt_pkg::PK_W-1:0]   result_packets
);

    import isqt_pkg::*;

    localparam int             IW   = $clog2(SLOTS);
    localparam int             RW   = ID_W + PK_W;
    localparam logic [IW-1:0]  LAST = IW'(SLOTS - 1);

    // control state
    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     pidx_reg, pidx_next;
    logic              pv_reg, pv_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     sel_reg, sel_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [ID_W-1:0]   nn_reg, nn_next;
    logic              out_valid_reg, out_valid_next;

    // request and scan payload
    func_t             func_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              excl_reg;
    logic [ID_W-1:0]   img_reg;
    logic [PK_W-1:0]   pk_reg;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [PK_W-1:0]   best_pk_reg, best_pk_next;

    // result payload
    logic              ok_reg, ok_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [PK_W-1:0]   rpk_reg, rpk_next;

    logic              in_acc;
    logic              res_load;
    logic              out_free;
    logic              ram_we;
    logic [RW-1:0]     ram_rdata;
    logic [ID_W-1:0]   rd_id;
    logic [PK_W-1:0]   rd_pk;
    logic [ID_W-1:0]   cmp_b;
    cmp_res_t          cmp_res;
    logic              excluded;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign result_slot    = rslot_reg;
    assign result_id      = rid_reg;
    assign result_packets = rpk_reg;

    // slot RAM: {image number, packet count}, read at the scan index
    assign ram_we = (state_reg == ST_FIN) && out_free && (func_reg == FUNC_STORE)
                    && found_reg && (pk_reg != '0);

    isqt_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sel_reg),
        .wdata ({nn_reg, pk_reg}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_id = ram_rdata[RW-1:PK_W];
    assign rd_pk = ram_rdata[PK_W-1:0];

    // shared comparator: lookup key or best-so-far number
    assign cmp_b = (func_reg == FUNC_LOOKUP) ? img_reg : best_id_reg;

    isqt_cmp u_cmp (
        .a   (rd_id),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign excluded = excl_reg && (32'(pidx_reg) == 32'(slot_reg));

    // sequencer, scan stage and result assembly
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        pv_next        = 1'b0;
        found_next     = found_reg;
        sel_next       = sel_reg;
        occ_next       = occ_reg;
        nn_next        = nn_reg;
        best_id_next   = best_id_reg;
        best_pk_next   = best_pk_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_load       = 1'b0;
        ok_next        = 1'b0;
        rslot_next     = '0;
        rid_next       = '0;
        rpk_next       = '0;

        // compare stage: RAM data for pidx_reg is valid this cycle
        if (pv_reg && occ_reg[pidx_reg])
        begin
            if (func_reg == FUNC_LOOKUP)
            begin
                if (!found_reg && cmp_res.eq)
                begin
                    found_next   = 1'b1;
                    sel_next     = pidx_reg;
                    best_pk_next = rd_pk;
                end
            end
            else if (func_reg == FUNC_OLDEST)
            begin
                if (!excluded && (!found_reg || cmp_res.earlier))
                begin
                    found_next   = 1'b1;
                    sel_next     = pidx_reg;
                    best_id_next = rd_id;
                    best_pk_next = rd_pk;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (func_t'(func) == FUNC_RELEASE) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (func_reg == FUNC_STORE)
                begin
                    // lowest free slot from the occupancy bits
                    if (!occ_reg[idx_reg])
                    begin
                        found_next = 1'b1;
                        sel_next   = idx_reg;
                        state_next = ST_FIN;
                    end
                    else if (idx_reg == LAST)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                else
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg;
                    if (idx_reg == LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (func_reg)
                        FUNC_STORE:
                        begin
                            if (found_reg)
                            begin
                                nn_next  = nn_reg + ID_W'(1);
                                rid_next = nn_reg;
                                if (pk_reg != '0)
                                begin
                                    occ_next[sel_reg] = 1'b1;
                                    ok_next           = 1'b1;
                                    rslot_next        = SLOT_W'(sel_reg);
                                    rpk_next          = pk_reg;
                                end
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (32'(slot_reg) < 32'(SLOTS))
                            begin
                                occ_next[IW'(slot_reg)] = 1'b0;
                                ok_next                 = 1'b1;
                                rslot_next              = slot_reg;
                            end
                        end
                        FUNC_OLDEST:
                        begin
                            if (found_reg)
                            begin
                                ok_next    = 1'b1;
                                rslot_next = SLOT_W'(sel_reg);
                                rid_next   = best_id_reg;
                                rpk_next   = best_pk_reg;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                ok_next    = 1'b1;
                                rslot_next = SLOT_W'(sel_reg);
                                rid_next   = img_reg;
                                rpk_next   = best_pk_reg;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            sel_reg       <= '0;
            occ_reg       <= '0;
            nn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pidx_reg      <= pidx_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            sel_reg       <= sel_next;
            occ_reg       <= occ_next;
            nn_reg        <= nn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture, best-so-far and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg <= func_t'(func);
            slot_reg <= slot;
            excl_reg <= exclude_enable;
            img_reg  <= image_id;
            pk_reg   <= packets;
        end
        best_id_reg <= best_id_next;
        best_pk_reg <= best_pk_next;
        if (res_load)
        begin
            ok_reg    <= ok_next;
            rslot_reg <= rslot_next;
            rid_reg   <= rid_next;
            rpk_reg   <= rpk_next;
        end
    end

    // checks
    `AST_NEXT(a_busy_after_accept, in_acc, state_reg != ST_IDLE,
              "request accepted but sequencer still idle")
    `AST_NEXT(a_fin_loads_result, (state_reg == ST_FIN) && out_free,
              out_valid_reg && (state_reg == ST_IDLE), "finished request not delivered")
    `AST_NEXT(a_number_only_at_fin, state_reg != ST_FIN, $stable(nn_reg),
              "image number counter moved outside result phase")
    `AST_IMPLY(a_ram_write_in_fin, ram_we, (state_reg == ST_FIN) && found_reg,
               "slot RAM written without a free slot")

endmodule
